### design/kfi_pkg.sv
// Shared types, widths and constants for the keyframe path interpolator.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package kfi_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int SPAN_W     = 24;
  localparam int PC_W       = 5;
  localparam int COORD_W    = 32;
  localparam int DELTA_W    = 16;
  localparam int FRAC_W     = 16;
  localparam int PIDX_W     = 4;
  localparam int CMD_W      = 2;
  // elapsed < span before a tick adds delta, so it stays below 2^(SPAN_W+1)
  localparam int ELAPSED_W  = SPAN_W + 1;
  localparam int T_W        = ELAPSED_W + IDX_W;
  localparam int STEP_W     = $clog2(T_W + 1);
  localparam int POINT_W    = 3 * COORD_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SPAN_W;

  localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(1000);
  localparam logic [PC_W-1:0]   PC_RESET   = PC_W'(2);
  localparam logic [FRAC_W-1:0] FRAC_MAX   = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPAN        = 1'b0,
    CFG_POINT_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TIME,
    ST_SEG_DIV,
    ST_SEG_CHK,
    ST_FRAC_DIV,
    ST_RD_A,
    ST_RD_B,
    ST_LERP_ISSUE,
    ST_LERP_DRAIN,
    ST_RD_LAST,
    ST_LAST_WR,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [SPAN_W-1:0] init_rem;
    logic [T_W-1:0]    dividend;
  } div_cmd_t;

  typedef struct packed {
    logic              done;
    logic [T_W-1:0]    quot;
    logic [SPAN_W-1:0] rem;
  } div_rsp_t;

endpackage

### design/kfi_if.sv
// Handshake channel interfaces: request input, result output, config writes.
// Depends on kfi_pkg for field widths.
`timescale 1ns / 1ps

interface kfi_in_if import kfi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic [PIDX_W-1:0]         point_index;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic [DELTA_W-1:0]        delta;

  modport source (output valid, cmd, point_index, coord_x, coord_y, coord_z, delta,
                  input ready);
  modport sink   (input valid, cmd, point_index, coord_x, coord_y, coord_z, delta,
                  output ready);
endinterface

interface kfi_out_if import kfi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic                      running;
  logic                      position_valid;

  modport source (output valid, pos_x, pos_y, pos_z, running, position_valid,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, running, position_valid,
                  output ready);
endinterface

interface kfi_cfg_if import kfi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/kfi_div_unit.sv
// Shared restoring divider, one quotient bit per cycle.
// Used for both segment search and fraction; depends on kfi_pkg.
`timescale 1ns / 1ps

module kfi_div_unit import kfi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  div_cmd_t          cmd,
  input  logic [SPAN_W-1:0] divisor,
  output div_rsp_t          rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [SPAN_W-1:0] rem_r, rem_nxt;
  logic [T_W-1:0]    dvd_r, dvd_nxt;
  logic [T_W-1:0]    quo_r, quo_nxt;
  logic [SPAN_W:0]   trial;
  logic              qbit;

  // partial remainder stays below the divisor, so trial fits SPAN_W+1 bits
  assign trial = {rem_r, dvd_r[T_W-1]};
  assign qbit  = (trial >= {1'b0, divisor});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = cmd.steps;
      rem_nxt  = cmd.init_rem;
      dvd_nxt  = cmd.dividend;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = qbit ? SPAN_W'(trial - {1'b0, divisor}) : trial[SPAN_W-1:0];
      dvd_nxt = {dvd_r[T_W-2:0], 1'b0};
      quo_nxt = {quo_r[T_W-2:0], qbit};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !busy_r)
    else $error("divider started while busy");

  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !cmd.start && cnt_r == STEP_W'(1)) |=> (done_r && !busy_r))
    else $error("divider did not finish after last step");

endmodule

### design/kfi_point_mem.sv
// Control point store: one write port, one read port, registered read data.
// Each word packs x, y, z; depends on kfi_pkg.
`timescale 1ns / 1ps

module kfi_point_mem import kfi_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [IDX_W-1:0]   waddr,
  input  logic [POINT_W-1:0] wdata,
  input  logic               re,
  input  logic [IDX_W-1:0]   raddr,
  output logic [POINT_W-1:0] rdata
);

  logic [POINT_W-1:0] mem [MAX_POINTS];
  logic [POINT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/kfi_lerp_unit.sv
// Three-stage lerp pipe: a + floor((b - a) * frac / 2^16), one axis per request.
// Shared across x, y, z; depends on kfi_pkg.
`timescale 1ns / 1ps

module kfi_lerp_unit import kfi_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic signed [COORD_W-1:0] a,
  input  logic signed [COORD_W-1:0] b,
  input  logic [FRAC_W-1:0]         frac,
  output logic                      res_valid,
  output logic signed [COORD_W-1:0] res
);

  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_W + 1;

  logic                      v0_r, v1_r, v2_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic signed [COORD_W-1:0] a0_r, a1_r;
  logic [FRAC_W-1:0]         frac_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [COORD_W-1:0] res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
    diff_r <= $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});
    a0_r   <= a;
    frac_r <= frac;
    prod_r <= PROD_W'(diff_r) * $signed({1'b0, frac_r});
    a1_r   <= a0_r;
    // arithmetic shift right by 16 is a floor; keep the low 32 bits
    res_r  <= a1_r + $signed(prod_r[FRAC_W +: COORD_W]);
  end

  assign res_valid = v2_r;
  assign res       = res_r;

endmodule

### design/linear_keyframe_path_interpolator_core.sv
// Keyframe path interpolator top: sequencer, state registers, output register.
// Depends on kfi_pkg, kfi_if, kfi_div_unit, kfi_point_mem, kfi_lerp_unit.
`timescale 1ns / 1ps
//
// Usage
//   in_chan  : requests. cmd LOAD writes control point point_index, START clears
//              elapsed time and sets running, TICK advances time by delta.
//   out_chan : one result per request: held position, running, position_valid.
//   cfg_chan : register writes (index 0 span, 1 point_count); always ready,
//              write only while no request is in flight.
// Sequence
//   LOAD, START, unknown commands and ticks that end or skip run pass from
//   acceptance through ST_EMIT to the output register. For a full tick, a 29-step
//   serial division finds the segment, a 16-step pass on the same divider
//   gives the fraction, two point reads, then the shared lerp pipe handles
//   x, y, z back to back. The divider sets the rate; one request at a time.
// Reset
//   rst_n (sync, active low) clears elapsed time, running, position_valid and
//   the held position; span returns to 1000 and point_count to 2. The point
//   store is not cleared: points must be loaded before use.
// Stalls
//   The result sits in an output register. A new request is taken while it
//   waits; that request's own result waits in ST_EMIT until out_chan drains.
//
module linear_keyframe_path_interpolator_core import kfi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  kfi_in_if.sink    in_chan,
  kfi_out_if.source out_chan,
  kfi_cfg_if.sink   cfg_chan
);

  state_t state_r, state_nxt;

  logic [SPAN_W-1:0]    span_r;
  logic [PC_W-1:0]      pc_r;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic                 active_r, active_nxt;
  logic                 has_pos_r, has_pos_nxt;
  logic [COORD_W-1:0]   held_x_r, held_x_nxt;
  logic [COORD_W-1:0]   held_y_r, held_y_nxt;
  logic [COORD_W-1:0]   held_z_r, held_z_nxt;
  logic [IDX_W-1:0]     seg_r, seg_nxt;
  logic [FRAC_W-1:0]    frac_r, frac_nxt;
  logic [POINT_W-1:0]   pa_r, pa_nxt;
  logic [1:0]           axis_r, axis_nxt;
  logic [1:0]           got_r, got_nxt;

  logic                 out_valid_r;
  logic [COORD_W-1:0]   out_x_r, out_y_r, out_z_r;
  logic                 out_run_r, out_pv_r;
  logic                 emit_go;

  logic                 in_acc;
  logic [SPAN_W-1:0]    sp;
  logic [PC_W-1:0]      n_cnt;
  logic [IDX_W-1:0]     nm1;
  logic [T_W-1:0]       t_val;
  logic [SPAN_W-1:0]    rem1;

  div_cmd_t             div_cmd;
  div_rsp_t             div_rsp;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_raddr;
  logic [POINT_W-1:0]   mem_rdata;

  logic                 lerp_in_valid;
  logic [COORD_W-1:0]   lerp_a, lerp_b;
  logic                 lerp_res_valid;
  logic [COORD_W-1:0]   lerp_res;

  // ---------------------------------------------------------------------------
  // Handshakes and derived values
  // ---------------------------------------------------------------------------
  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign emit_go        = (state_r == ST_EMIT) && (!out_valid_r || out_chan.ready);

  // zero span behaves as one
  assign sp = (span_r == '0) ? SPAN_W'(1) : span_r;

  // point count clamped to [2, MAX_POINTS]
  always_comb begin
    if (pc_r < PC_W'(2)) begin
      n_cnt = PC_W'(2);
    end else if (32'(pc_r) > MAX_POINTS) begin
      n_cnt = PC_W'(MAX_POINTS);
    end else begin
      n_cnt = pc_r;
    end
  end
  assign nm1 = IDX_W'(n_cnt - PC_W'(1));

  // scaled time, t = elapsed * (n-1); narrow constant-width multiply
  assign t_val = T_W'(elapsed_r) * T_W'(nm1);

  // remainder of (t-1)/span, plus one, gives 0 < rem <= span
  assign rem1 = div_rsp.rem + SPAN_W'(1);

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.cmd == CMD_TICK && active_r && (elapsed_r < ELAPSED_W'(sp))) begin
            state_nxt = ST_TIME;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_TIME: begin
        state_nxt = (t_val == '0) ? ST_RD_A : ST_SEG_DIV;
      end
      ST_SEG_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_SEG_CHK;
        end
      end
      ST_SEG_CHK: begin
        if (div_rsp.quot == T_W'(nm1)) begin
          state_nxt = ST_EMIT;           // final segment: position holds
        end else if (div_rsp.quot > T_W'(nm1)) begin
          state_nxt = ST_RD_LAST;        // past the end: take the last point
        end else if (rem1 == sp) begin
          state_nxt = ST_RD_A;           // fraction saturates, no division
        end else begin
          state_nxt = ST_FRAC_DIV;
        end
      end
      ST_FRAC_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_RD_A;
        end
      end
      ST_RD_A:       state_nxt = ST_RD_B;
      ST_RD_B:       state_nxt = ST_LERP_ISSUE;
      ST_LERP_ISSUE: begin
        if (axis_r == 2'd2) begin
          state_nxt = ST_LERP_DRAIN;
        end
      end
      ST_LERP_DRAIN: begin
        if (lerp_res_valid && got_r == 2'd2) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_RD_LAST:    state_nxt = ST_LAST_WR;
      ST_LAST_WR:    state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: datapath controls and register next values
  // ---------------------------------------------------------------------------
  always_comb begin
    elapsed_nxt   = elapsed_r;
    active_nxt    = active_r;
    has_pos_nxt   = has_pos_r;
    held_x_nxt    = held_x_r;
    held_y_nxt    = held_y_r;
    held_z_nxt    = held_z_r;
    seg_nxt       = seg_r;
    frac_nxt      = frac_r;
    pa_nxt        = pa_r;
    axis_nxt      = axis_r;
    got_nxt       = got_r;
    div_cmd       = '0;
    mem_we        = 1'b0;
    mem_waddr     = IDX_W'(in_chan.point_index);
    mem_re        = 1'b0;
    mem_raddr     = seg_r;
    lerp_in_valid = 1'b0;

    case (axis_r)
      2'd0: begin
        lerp_a = pa_r[2*COORD_W +: COORD_W];
        lerp_b = mem_rdata[2*COORD_W +: COORD_W];
      end
      2'd1: begin
        lerp_a = pa_r[COORD_W +: COORD_W];
        lerp_b = mem_rdata[COORD_W +: COORD_W];
      end
      default: begin
        lerp_a = pa_r[0 +: COORD_W];
        lerp_b = mem_rdata[0 +: COORD_W];
      end
    endcase

    // lerp results arrive x, y, z in order; shift them into the held position
    if (lerp_res_valid) begin
      held_x_nxt = held_y_r;
      held_y_nxt = held_z_r;
      held_z_nxt = lerp_res;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_chan.cmd)
            CMD_LOAD: begin
              mem_we = (32'(in_chan.point_index) < MAX_POINTS);
            end
            CMD_START: begin
              elapsed_nxt = '0;
              active_nxt  = 1'b1;
              has_pos_nxt = 1'b0;
            end
            CMD_TICK: begin
              if (active_r) begin
                if (elapsed_r >= ELAPSED_W'(sp)) begin
                  active_nxt = 1'b0;
                end else begin
                  elapsed_nxt = elapsed_r + ELAPSED_W'(in_chan.delta);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_TIME: begin
        if (t_val == '0) begin
          seg_nxt  = '0;
          frac_nxt = '0;
        end else begin
          div_cmd.start    = 1'b1;
          div_cmd.steps    = STEP_W'(T_W);
          div_cmd.init_rem = '0;
          div_cmd.dividend = t_val - T_W'(1);
        end
      end
      ST_SEG_CHK: begin
        seg_nxt = div_rsp.quot[IDX_W-1:0];
        if (div_rsp.quot < T_W'(nm1)) begin
          if (rem1 == sp) begin
            frac_nxt = FRAC_MAX;
          end else begin
            div_cmd.start    = 1'b1;
            div_cmd.steps    = STEP_W'(FRAC_W);
            div_cmd.init_rem = rem1;
            div_cmd.dividend = '0;
          end
        end
      end
      ST_FRAC_DIV: begin
        if (div_rsp.done) begin
          frac_nxt = div_rsp.quot[FRAC_W-1:0];
        end
      end
      ST_RD_A: begin
        mem_re    = 1'b1;
        mem_raddr = seg_r;
      end
      ST_RD_B: begin
        mem_re    = 1'b1;
        mem_raddr = seg_r + IDX_W'(1);
        pa_nxt    = mem_rdata;
        axis_nxt  = 2'd0;
        got_nxt   = 2'd0;
      end
      ST_LERP_ISSUE: begin
        lerp_in_valid = 1'b1;
        axis_nxt      = axis_r + 2'd1;
      end
      ST_LERP_DRAIN: begin
        if (lerp_res_valid) begin
          got_nxt = got_r + 2'd1;
          if (got_r == 2'd2) begin
            has_pos_nxt = 1'b1;
          end
        end
      end
      ST_RD_LAST: begin
        mem_re    = 1'b1;
        mem_raddr = nm1;
      end
      ST_LAST_WR: begin
        held_x_nxt  = mem_rdata[2*COORD_W +: COORD_W];
        held_y_nxt  = mem_rdata[COORD_W +: COORD_W];
        held_z_nxt  = mem_rdata[0 +: COORD_W];
        has_pos_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      span_r      <= SPAN_RESET;
      pc_r        <= PC_RESET;
      elapsed_r   <= '0;
      active_r    <= 1'b0;
      has_pos_r   <= 1'b0;
      held_x_r    <= '0;
      held_y_r    <= '0;
      held_z_r    <= '0;
      axis_r      <= '0;
      got_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      elapsed_r <= elapsed_nxt;
      active_r  <= active_nxt;
      has_pos_r <= has_pos_nxt;
      held_x_r  <= held_x_nxt;
      held_y_r  <= held_y_nxt;
      held_z_r  <= held_z_nxt;
      axis_r    <= axis_nxt;
      got_r     <= got_nxt;
      if (cfg_chan.valid) begin
        case (cfg_chan.index)
          CFG_SPAN:        span_r <= cfg_chan.data[SPAN_W-1:0];
          CFG_POINT_COUNT: pc_r   <= cfg_chan.data[PC_W-1:0];
          default: begin
          end
        endcase
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    seg_r  <= seg_nxt;
    frac_r <= frac_nxt;
    pa_r   <= pa_nxt;
    if (emit_go) begin
      out_x_r   <= held_x_r;
      out_y_r   <= held_y_r;
      out_z_r   <= held_z_r;
      out_run_r <= active_r;
      out_pv_r  <= has_pos_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.pos_x          = out_x_r;
  assign out_chan.pos_y          = out_y_r;
  assign out_chan.pos_z          = out_z_r;
  assign out_chan.running        = out_run_r;
  assign out_chan.position_valid = out_pv_r;

  // ---------------------------------------------------------------------------
  // Submodules
  // ---------------------------------------------------------------------------
  kfi_div_unit u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (div_cmd),
    .divisor (sp),
    .rsp     (div_rsp)
  );

  kfi_point_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata ({in_chan.coord_x, in_chan.coord_y, in_chan.coord_z}),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  kfi_lerp_unit u_lerp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lerp_in_valid),
    .a         (lerp_a),
    .b         (lerp_b),
    .frac      (frac_r),
    .res_valid (lerp_res_valid),
    .res       (lerp_res)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.cmd == CMD_TICK && !active_r) |=> !active_r)
    else $error("tick while stopped changed running");

  a_pos_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(has_pos_r) |-> ($past(state_r == ST_LERP_DRAIN) || $past(state_r == ST_LAST_WR)))
    else $error("position_valid set outside a tick");

  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not loaded into output register");

endmodule

### test/linear_keyframe_path_interpolator_core_test.sv
// Self-checking bench for linear_keyframe_path_interpolator_core: random and directed
// requests with config phases, checked against an in-bench keyframe path predictor.
// Depends on kfi_pkg, kfi_if and the design sources.
`timescale 1ns / 1ps

module linear_keyframe_path_interpolator_core_test;
  import kfi_pkg::*;

  // cmd value the block has no meaning for; must change nothing
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int TARGET_REQS   = 950;   // stimulus stops near this many live requests
  localparam int SETTLE_CYCLES = 4;     // quiet cycles before a register write
  localparam int CALM_TAIL     = 80;    // last requests run with no idling at all
  localparam int TAIL_CYCLES   = 80;    // drain time after the last result
  localparam int IDLE_LIMIT    = 5000;  // cycles with no handshake before giving up
  localparam int MAX_REPORTS   = 10;

  // One entry of the stimulus queue: either a request or a register write.
  typedef struct packed {
    logic                      is_write;
    logic [CMD_W-1:0]          cmd;
    logic [PIDX_W-1:0]         slot;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [DELTA_W-1:0]        delta;
    cfg_reg_e                  sel;
    logic [CFG_DATA_W-1:0]     value;
  } pending_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      running;
    logic                      pos_valid;
  } position_t;

  logic clk = 1'b0;
  logic rst_n;

  kfi_in_if  in_ch ();
  kfi_out_if out_ch ();
  kfi_cfg_if cfg_ch ();

  linear_keyframe_path_interpolator_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_chan (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Path predictor: control point table, run state and the two registers.
  // ---------------------------------------------------------------------------
  logic signed [COORD_W-1:0] path_x [MAX_POINTS];
  logic signed [COORD_W-1:0] path_y [MAX_POINTS];
  logic signed [COORD_W-1:0] path_z [MAX_POINTS];
  logic [31:0]               clock_elapsed = '0;
  logic                      run_active    = 1'b0;
  logic                      have_pos      = 1'b0;
  logic signed [COORD_W-1:0] hold_x = '0, hold_y = '0, hold_z = '0;
  logic [SPAN_W-1:0]         span_val  = SPAN_RESET;
  logic [PC_W-1:0]           count_val = PC_RESET;

  // what the run went through
  int unsigned loads_seen, starts_seen, ticks_seen, runs_ended;
  int unsigned past_end_snaps, final_holds, moves_seen;

  pending_t  pending[$];       // stimulus not yet accepted
  position_t results_due[$];   // predicted positions awaiting the block
  int unsigned total_reqs, reqs_sent, cfg_writes, results_checked, mismatches;
  logic        calm = 1'b0;

  // a + floor((b - a) * f / 2^16), wrapped to the coordinate width
  function automatic logic signed [COORD_W-1:0] blend(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b,
                                                      input logic [FRAC_W-1:0] f);
    longint da, db, fw, prod;
    da   = a;
    db   = b;
    fw   = f;
    prod = (db - da) * fw;
    return COORD_W'(da + (prod >>> FRAC_W));
  endfunction

  function automatic void advance_clock(input logic [DELTA_W-1:0] d);
    longint unsigned sp, n, t, seg, rem, frac;
    if (!run_active) return;
    sp = (span_val == '0) ? 64'd1 : 64'(span_val);
    // time already used up: this tick only ends the run
    if (64'(clock_elapsed) >= sp) begin
      run_active = 1'b0;
      runs_ended++;
      return;
    end
    clock_elapsed = clock_elapsed + 32'(d);
    n = (count_val < 2) ? 64'd2 : ((count_val > MAX_POINTS) ? 64'(MAX_POINTS) : 64'(count_val));
    t = 64'(clock_elapsed) * (n - 1);
    if (t == 0) begin
      seg = 0;
      rem = 0;
    end else begin
      seg = (t - 1) / sp;
      rem = t - seg * sp;
    end
    // on the last segment the position stays put
    if (seg == n - 1) begin
      final_holds++;
      return;
    end
    // beyond the table: snap to the last point in use
    if (seg >= n) begin
      hold_x = path_x[n - 1];
      hold_y = path_y[n - 1];
      hold_z = path_z[n - 1];
      have_pos = 1'b1;
      past_end_snaps++;
      return;
    end
    frac = (rem << FRAC_W) / sp;
    if (frac > 64'(FRAC_MAX)) frac = 64'(FRAC_MAX);
    hold_x = blend(path_x[seg], path_x[seg + 1], FRAC_W'(frac));
    hold_y = blend(path_y[seg], path_y[seg + 1], FRAC_W'(frac));
    hold_z = blend(path_z[seg], path_z[seg + 1], FRAC_W'(frac));
    have_pos = 1'b1;
    moves_seen++;
  endfunction

  function automatic position_t apply_request(input pending_t p);
    position_t r;
    case (p.cmd)
      CMD_LOAD: begin
        path_x[p.slot] = p.x;
        path_y[p.slot] = p.y;
        path_z[p.slot] = p.z;
        loads_seen++;
      end
      CMD_START: begin
        clock_elapsed = '0;
        run_active    = 1'b1;
        have_pos      = 1'b0;
        starts_seen++;
      end
      CMD_TICK: begin
        ticks_seen++;
        advance_clock(p.delta);
      end
      default: ;
    endcase
    r.pos_x     = hold_x;
    r.pos_y     = hold_y;
    r.pos_z     = hold_z;
    r.running   = run_active;
    r.pos_valid = have_pos;
    return r;
  endfunction

  function automatic void apply_write(input pending_t p);
    case (p.sel)
      CFG_SPAN:        span_val  = p.value[SPAN_W-1:0];
      CFG_POINT_COUNT: count_val = p.value[PC_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation. The generator tracks which slots hold a point so that
  // no tick ever reads one that was never loaded.
  // ---------------------------------------------------------------------------
  logic [MAX_POINTS-1:0] gen_loaded = '0;
  int unsigned           gen_points = 2;
  int unsigned           gen_span   = 1000;
  int unsigned           queued_reqs;

  function automatic void queue_load(input int unsigned slot, input logic [COORD_W-1:0] x,
                                     input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
    pending_t p;
    p          = '0;
    p.cmd      = CMD_LOAD;
    p.slot     = PIDX_W'(slot);
    p.x        = x;
    p.y        = y;
    p.z        = z;
    p.delta    = DELTA_W'($urandom);
    p.sel      = CFG_SPAN;
    pending.push_back(p);
    gen_loaded[slot] = 1'b1;
    queued_reqs++;
  endfunction

  // start, tick or unused command; fields the command ignores carry noise
  function automatic void queue_op(input logic [CMD_W-1:0] cmd, input logic [DELTA_W-1:0] d);
    pending_t p;
    p       = '0;
    p.cmd   = cmd;
    p.slot  = PIDX_W'($urandom);
    p.x     = $urandom;
    p.y     = $urandom;
    p.z     = $urandom;
    p.delta = d;
    p.sel   = CFG_SPAN;
    pending.push_back(p);
    if (cmd != CMD_UNUSED) queued_reqs++;
  endfunction

  function automatic void queue_write(input cfg_reg_e sel, input int unsigned value);
    pending_t p;
    p          = '0;
    p.is_write = 1'b1;
    p.sel      = sel;
    p.value    = CFG_DATA_W'(value);
    pending.push_back(p);
    if (sel == CFG_SPAN) begin
      gen_span = (p.value == '0) ? 1 : int'(p.value);
    end else begin
      gen_points = (p.value[PC_W-1:0] < 2) ? 2 :
                   ((p.value[PC_W-1:0] > MAX_POINTS) ? MAX_POINTS : int'(p.value[PC_W-1:0]));
    end
  endfunction

  function automatic void fill_missing();
    for (int i = 0; i < gen_points; i++)
      if (!gen_loaded[i]) queue_load(i, $urandom, $urandom, $urandom);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return COORD_W'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DELTA_W-1:0] pick_delta(input int unsigned base);
    int unsigned r, v;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 10) return '1;
    if (r < 15) return DELTA_W'($urandom);
    v = base + $urandom_range(0, base / 2 + 1);
    return (v > 65535) ? '1 : DELTA_W'(v);
  endfunction

  function automatic int unsigned pick_span();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return $urandom_range(1, 40);
    if (r < 7) return $urandom_range(41, 60000);
    if (r < 9) return $urandom & 32'h00FF_FFFF;
    return 32'h00FF_FFFF;
  endfunction

  function automatic int unsigned pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom_range(0, 1);
    if (r < 15) return $urandom_range(MAX_POINTS + 1, 31);
    if (r < 30) return MAX_POINTS;
    return $urandom_range(2, MAX_POINTS);
  endfunction

  // mostly well-formed runs: a start, then ticks paced to cross the whole
  // span in a random number of steps, with loads, restarts and junk mixed in
  function automatic void random_run(input int unsigned len);
    int unsigned pace, base, r;
    pace = $urandom_range(1, 30);
    base = gen_span / pace;
    if ($urandom_range(0, 6) != 0) queue_op(CMD_START, DELTA_W'($urandom));
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 6)       queue_load($urandom_range(0, MAX_POINTS - 1), pick_coord(), pick_coord(),
                                  pick_coord());
      else if (r < 11) queue_op(CMD_START, DELTA_W'($urandom));
      else if (r < 14) queue_op(CMD_UNUSED, DELTA_W'($urandom));
      else             queue_op(CMD_TICK, pick_delta(base));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Idle pattern: each time the 8-bit mode timer wraps, pick a new stall rate, sometimes none.
  // ---------------------------------------------------------------------------
  logic [7:0]  mode_timer = '0;
  int unsigned stall_pct  = 20;

  always @(posedge clk) begin
    mode_timer <= mode_timer + 8'd1;
    if (mode_timer == '1) stall_pct <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
  end

  // ---------------------------------------------------------------------------
  // Driver: requests and register writes from the queue, in order. A write
  // waits until every predicted result has come back and the block is quiet.
  // ---------------------------------------------------------------------------
  logic        next_in, next_cfg;
  int unsigned send_gap, settle;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      cfg_ch.valid <= 1'b0;
    end else begin
      next_in  = 1'b0;
      next_cfg = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        results_due.push_back(apply_request(pending.pop_front()));
        reqs_sent++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        apply_write(pending.pop_front());
        cfg_writes++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        next_in = 1'b1;                       // request still on offer
      end else if (cfg_ch.valid && !cfg_ch.ready) begin
        next_cfg = 1'b1;
      end else if (send_gap != 0) begin
        send_gap--;
      end else if (pending.size() != 0) begin
        if (pending[0].is_write) begin
          if (results_due.size() != 0) begin
            settle = 0;
          end else if (settle == SETTLE_CYCLES) begin
            settle   = 0;
            next_cfg = 1'b1;
          end else begin
            settle++;
          end
        end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
          send_gap = $urandom_range(0, 12);   // stall: send nothing until the gap counts down
        end else begin
          next_in = 1'b1;
        end
      end
      if (next_in) begin
        in_ch.cmd         <= pending[0].cmd;
        in_ch.point_index <= pending[0].slot;
        in_ch.coord_x     <= pending[0].x;
        in_ch.coord_y     <= pending[0].y;
        in_ch.coord_z     <= pending[0].z;
        in_ch.delta       <= pending[0].delta;
      end
      if (next_cfg) begin
        cfg_ch.index <= pending[0].sel;
        cfg_ch.data  <= pending[0].value;
      end
      in_ch.valid  <= next_in;
      cfg_ch.valid <= next_cfg;
      calm         <= (reqs_sent + CALM_TAIL >= total_reqs);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted result with the oldest prediction.
  // ---------------------------------------------------------------------------
  logic        next_ready;
  int unsigned recv_gap;
  position_t   want, seen;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen.pos_x     = out_ch.pos_x;
        seen.pos_y     = out_ch.pos_y;
        seen.pos_z     = out_ch.pos_z;
        seen.running   = out_ch.running;
        seen.pos_valid = out_ch.position_valid;
        results_checked++;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with no request outstanding: x=%h y=%h z=%h run=%b vld=%b",
                     $realtime, seen.pos_x, seen.pos_y, seen.pos_z, seen.running,
                     seen.pos_valid);
        end else begin
          want = results_due.pop_front();
          if (seen.pos_x !== want.pos_x || seen.pos_y !== want.pos_y ||
              seen.pos_z !== want.pos_z || seen.running !== want.running ||
              seen.pos_valid !== want.pos_valid) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: result %0d expected x=%h y=%h z=%h run=%b vld=%b, got x=%h y=%h z=%h run=%b vld=%b",
                       $realtime, results_checked, want.pos_x, want.pos_y, want.pos_z,
                       want.running, want.pos_valid, seen.pos_x, seen.pos_y, seen.pos_z,
                       seen.running, seen.pos_valid);
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        next_ready = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        recv_gap   = $urandom_range(0, 12);
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      out_ch.ready <= next_ready;
    end
  end

  // Watchdog: too long without any handshake means the block is stuck.
  int unsigned idle_cycles;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("no handshake for %0d cycles, %0d requests still queued, %0d results due",
               IDLE_LIMIT, pending.size(), results_due.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = CMD_LOAD;
    in_ch.point_index  = '0;
    in_ch.coord_x      = '0;
    in_ch.coord_y      = '0;
    in_ch.coord_z      = '0;
    in_ch.delta        = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_SPAN;
    cfg_ch.data        = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      path_x[i] = '0;
      path_y[i] = '0;
      path_z[i] = '0;
    end

    // Directed part, reset registers: span 1000, two points.
    queue_op(CMD_TICK, 16'd100);                 // tick with nothing running
    queue_op(CMD_UNUSED, 16'd0);
    queue_load(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    queue_load(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_op(CMD_START, 16'd0);
    queue_op(CMD_TICK, 16'd0);                   // zero time: first point exactly
    queue_op(CMD_TICK, 16'd1);
    queue_op(CMD_TICK, 16'd499);
    queue_op(CMD_TICK, 16'd500);                 // lands on span: fraction saturates
    queue_op(CMD_TICK, 16'd7);                   // time used up: run ends
    queue_op(CMD_TICK, 16'hFFFF);                // stopped, no change
    queue_op(CMD_START, 16'd0);                  // keeps position, clears valid
    queue_op(CMD_TICK, 16'hFFFF);                // far past the table: last point
    queue_op(CMD_TICK, 16'd0);
    queue_op(CMD_START, 16'd0);
    queue_op(CMD_TICK, 16'd1500);                // final segment: position holds
    queue_load(1, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
    queue_op(CMD_START, 16'd0);
    queue_op(CMD_TICK, 16'd250);                 // uses the point just reloaded
    queue_load(0, pick_coord(), pick_coord(), pick_coord());   // load mid-run
    queue_op(CMD_TICK, 16'd250);
    queue_op(CMD_TICK, 16'hFFFF);
    queue_op(CMD_TICK, 16'd0);

    // Register extremes, including out-of-range count and zero span.
    queue_write(CFG_SPAN, 1);
    queue_write(CFG_POINT_COUNT, MAX_POINTS);
    fill_missing();
    random_run(30);
    queue_write(CFG_SPAN, 32'h00FF_FFFF);
    queue_write(CFG_POINT_COUNT, 31);
    random_run(30);
    queue_write(CFG_SPAN, 0);
    queue_write(CFG_POINT_COUNT, 1);
    random_run(25);
    queue_write(CFG_SPAN, 5);
    queue_write(CFG_POINT_COUNT, MAX_POINTS + 1);
    random_run(30);
    queue_write(CFG_SPAN, 1000);
    queue_write(CFG_POINT_COUNT, 0);
    random_run(25);
    queue_write(CFG_POINT_COUNT, 2);
    random_run(30);

    // Random phases, new settings between them.
    while (queued_reqs < TARGET_REQS) begin
      if ($urandom_range(0, 3) != 0) queue_write(CFG_SPAN, pick_span());
      if ($urandom_range(0, 2) != 0) queue_write(CFG_POINT_COUNT, pick_count());
      fill_missing();
      random_run($urandom_range(20, 50));
    end

    foreach (pending[i])
      if (!pending[i].is_write) total_reqs++;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("requests %0d: loads %0d, starts %0d, ticks %0d; register writes %0d",
             reqs_sent, loads_seen, starts_seen, ticks_seen, cfg_writes);
    $display("moves %0d, past-end snaps %0d, final-segment holds %0d, runs ended %0d, mismatches %0d",
             moves_seen, past_end_snaps, final_holds, runs_ended, mismatches);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
design/kfi_pkg.sv
design/kfi_if.sv
design/kfi_div_unit.sv
design/kfi_point_mem.sv
design/kfi_lerp_unit.sv
design/linear_keyframe_path_interpolator_core.sv
test/linear_keyframe_path_interpolator_core_test.sv
